// File: hw/rtl/pfot_pkg.sv
// Shared types and constants of the page frame occupancy tracker.
// Used by every module of the block but pfot_ram; depends on nothing.
`timescale 1ns / 1ps

package pfot_pkg;

  localparam int CMD_W  = 2;
  localparam int ADDR_W = 14;
  localparam int LEN_W  = 15;
  localparam int ST_W   = 3;
  localparam int FF_W   = 6;
  localparam int PS_W   = 9;
  localparam int MS_W   = 15;
  localparam int APB_AW = 3;
  localparam int APB_DW = 32;
  // working width for addresses, bases and range ends
  localparam int WW     = 16;

  localparam logic [CMD_W-1:0] CMD_MARK = 2'd0;
  localparam logic [CMD_W-1:0] CMD_FREE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_FIND = 2'd2;

  localparam logic [ST_W-1:0] ST_OK    = 3'd0;
  localparam logic [ST_W-1:0] ST_RANGE = 3'd1;
  localparam logic [ST_W-1:0] ST_ZERO  = 3'd2;
  localparam logic [ST_W-1:0] ST_LARGE = 3'd3;
  localparam logic [ST_W-1:0] ST_NONE  = 3'd4;

  localparam logic REG_PAGE_SIZE = 1'b0;
  localparam logic REG_MEM_SIZE  = 1'b1;

  localparam logic [PS_W-1:0] PAGE_SIZE_RST = 9'd32;
  localparam logic [MS_W-1:0] MEM_SIZE_RST  = 15'd1024;
  localparam logic [MS_W-1:0] MEM_LIMIT     = 15'd16384;

  typedef struct packed {
    logic [PS_W-1:0] page;
    logic [MS_W-1:0] mem;
  } cfg_t;

  typedef struct packed {
    logic            start;
    logic [MS_W-1:0] dividend;
  } div_req_t;

  typedef struct packed {
    logic            done;
    logic [MS_W-1:0] quot;
    logic [PS_W-1:0] rem;
  } div_rsp_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_WDIVF,
    S_LIMIT,
    S_CHECK,
    S_WDIVA,
    S_WRD,
    S_WUPD,
    S_FRD,
    S_FCHK,
    S_DONE
  } state_t;

endpackage

// File: hw/rtl/pfot_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module pfot_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: hw/rtl/pfot_div.sv
// Restoring divider, one quotient bit per cycle, shared by the sequencer.
// Depends on pfot_pkg.
`timescale 1ns / 1ps

module pfot_div (
  input  logic               clk,
  input  logic               rst_n,
  input  pfot_pkg::div_req_t req,
  input  logic [pfot_pkg::PS_W-1:0] divisor,
  output pfot_pkg::div_rsp_t rsp
);
  import pfot_pkg::*;

  localparam int CW = $clog2(MS_W);

  logic            busy_r, busy_nxt;
  logic            done_r, done_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic [MS_W-1:0] dq_r, dq_nxt;
  logic [PS_W-1:0] rem_r, rem_nxt;
  logic [PS_W-1:0] dvs_r, dvs_nxt;
  logic [PS_W:0]   trial;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    dq_nxt   = dq_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    trial    = {rem_r, dq_r[MS_W-1]};
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      dq_nxt   = req.dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      if (trial >= {1'b0, dvs_r}) begin
        rem_nxt = PS_W'(trial - {1'b0, dvs_r});
        dq_nxt  = {dq_r[MS_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[PS_W-1:0];
        dq_nxt  = {dq_r[MS_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CW'(MS_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dq_r  <= dq_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quot = dq_r;
  assign rsp.rem  = rem_r;

endmodule

// File: hw/rtl/pfot_ctrl.sv
// Command sequencer: frame count, range check, frame walk and first-fit search.
// Depends on pfot_pkg, pfot_div and pfot_ram.
`timescale 1ns / 1ps

module pfot_ctrl #(
  parameter int unsigned MAX_FRAMES     = 64,
  parameter int unsigned MAX_PAGE_BYTES = 256
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  pfot_pkg::cfg_t                cfg,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [pfot_pkg::CMD_W-1:0]    in_cmd,
  input  logic [pfot_pkg::ADDR_W-1:0]   in_address,
  input  logic [pfot_pkg::LEN_W-1:0]    in_length,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [pfot_pkg::ST_W-1:0]     out_status,
  output logic [pfot_pkg::FF_W-1:0]     out_found_frame,
  output logic [pfot_pkg::ADDR_W-1:0]   out_found_address
);
  import pfot_pkg::*;

  localparam int FW   = $clog2(MAX_FRAMES);
  localparam int FCW  = $clog2(MAX_FRAMES + 1);
  localparam int PCAP = (MAX_PAGE_BYTES < 511) ? MAX_PAGE_BYTES : 511;
  localparam int UW   = $clog2(PCAP + 1);

  state_t            state_r, state_nxt;
  logic [CMD_W-1:0]  cmd_r, cmd_nxt;
  logic [ADDR_W-1:0] addr_r, addr_nxt;
  logic [LEN_W-1:0]  len_r, len_nxt;
  logic [FCW-1:0]    frames_r, frames_nxt;
  logic [WW-1:0]     limit_r, limit_nxt;
  logic [FW-1:0]     f_r, f_nxt;
  logic [WW-1:0]     base_r, base_nxt;
  logic [WW-1:0]     last_r, last_nxt;
  logic [ST_W-1:0]   status_r, status_nxt;
  logic [FF_W-1:0]   ff_r, ff_nxt;
  logic [ADDR_W-1:0] fa_r, fa_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [ST_W-1:0]   out_status_r, out_status_nxt;
  logic [FF_W-1:0]   out_ff_r, out_ff_nxt;
  logic [ADDR_W-1:0] out_fa_r, out_fa_nxt;

  div_req_t          div_req;
  div_rsp_t          div_rsp;

  logic              ram_we, ram_re;
  logic [UW:0]       ram_wdata, ram_rdata;

  logic [WW-1:0]     p16, addr16, len16, used16, ue, lo, top, hi, cov;
  logic [WW-1:0]     mark_sum, new_used, step_base;
  logic              occ, fit;

  pfot_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (div_req),
    .divisor (cfg.page),
    .rsp     (div_rsp)
  );

  pfot_ram #(
    .WIDTH (UW + 1),
    .DEPTH (MAX_FRAMES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (f_r),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (f_r),
    .rdata (ram_rdata)
  );

  // per-frame arithmetic on the entry just read
  always_comb begin
    p16       = WW'(cfg.page);
    addr16    = WW'(addr_r);
    len16     = WW'(len_r);
    occ       = ram_rdata[UW];
    used16    = WW'(ram_rdata[UW-1:0]);
    ue        = (used16 > p16) ? p16 : used16;
    fit       = !occ && ((p16 - ue) >= len16);
    lo        = (addr16 > base_r) ? addr16 : base_r;
    top       = base_r + p16 - 1'b1;
    hi        = (last_r < top) ? last_r : top;
    cov       = hi - lo + 1'b1;
    mark_sum  = used16 + cov;
    step_base = base_r + p16;
    if (cmd_r == CMD_MARK) begin
      new_used = (mark_sum > p16) ? p16 : mark_sum;
    end else begin
      new_used = (used16 > cov) ? used16 - cov : '0;
    end
  end

  always_comb begin
    state_nxt        = state_r;
    cmd_nxt          = cmd_r;
    addr_nxt         = addr_r;
    len_nxt          = len_r;
    frames_nxt       = frames_r;
    limit_nxt        = limit_r;
    f_nxt            = f_r;
    base_nxt         = base_r;
    last_nxt         = last_r;
    status_nxt       = status_r;
    ff_nxt           = ff_r;
    fa_nxt           = fa_r;
    out_valid_nxt    = out_valid_r && out_stall;
    out_status_nxt   = out_status_r;
    out_ff_nxt       = out_ff_r;
    out_fa_nxt       = out_fa_r;
    div_req.start    = 1'b0;
    div_req.dividend = cfg.mem;
    ram_we           = 1'b0;
    ram_re           = 1'b0;
    ram_wdata        = '0;

    unique case (state_r)
      S_CLEAR: begin
        ram_we = 1'b1;
        f_nxt  = f_r + 1'b1;
        if (f_r == FW'(MAX_FRAMES - 1)) begin
          f_nxt     = '0;
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd_nxt    = in_cmd;
          addr_nxt   = in_address;
          len_nxt    = in_length;
          status_nxt = ST_OK;
          ff_nxt     = '0;
          fa_nxt     = '0;
          priority if (in_cmd == CMD_MARK || in_cmd == CMD_FREE) begin
            if (in_length == '0) begin
              status_nxt = ST_ZERO;
              state_nxt  = S_DONE;
            end else begin
              div_req.start = 1'b1;
              state_nxt     = S_WDIVF;
            end
          end else if (in_cmd == CMD_FIND) begin
            if (WW'(in_length) > p16) begin
              status_nxt = ST_LARGE;
              state_nxt  = S_DONE;
            end else begin
              div_req.start = 1'b1;
              state_nxt     = S_WDIVF;
            end
          end else begin
            state_nxt = S_DONE;
          end
        end
      end
      S_WDIVF: begin
        if (div_rsp.done) begin
          frames_nxt = (WW'(div_rsp.quot) > WW'(MAX_FRAMES)) ? FCW'(MAX_FRAMES)
                                                             : FCW'(div_rsp.quot);
          state_nxt  = S_LIMIT;
        end
      end
      S_LIMIT: begin
        limit_nxt = WW'(frames_r) * p16;
        if (cmd_r == CMD_FIND) begin
          f_nxt    = '0;
          base_nxt = '0;
          if (frames_r == '0) begin
            status_nxt = ST_NONE;
            state_nxt  = S_DONE;
          end else begin
            state_nxt = S_FRD;
          end
        end else begin
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (addr16 + len16 > limit_r) begin
          status_nxt = ST_RANGE;
          state_nxt  = S_DONE;
        end else begin
          div_req.start    = 1'b1;
          div_req.dividend = MS_W'(addr_r);
          state_nxt        = S_WDIVA;
        end
      end
      S_WDIVA: begin
        if (div_rsp.done) begin
          f_nxt     = FW'(div_rsp.quot);
          base_nxt  = addr16 - WW'(div_rsp.rem);
          last_nxt  = addr16 + len16 - 1'b1;
          state_nxt = S_WRD;
        end
      end
      S_WRD: begin
        ram_re    = 1'b1;
        state_nxt = S_WUPD;
      end
      S_WUPD: begin
        ram_we    = 1'b1;
        ram_wdata = {cmd_r == CMD_MARK, UW'(new_used)};
        if (step_base > last_r) begin
          state_nxt = S_DONE;
        end else begin
          f_nxt     = f_r + 1'b1;
          base_nxt  = step_base;
          state_nxt = S_WRD;
        end
      end
      S_FRD: begin
        ram_re    = 1'b1;
        state_nxt = S_FCHK;
      end
      S_FCHK: begin
        if (fit) begin
          ff_nxt    = FF_W'(f_r);
          fa_nxt    = ADDR_W'(base_r + ue);
          state_nxt = S_DONE;
        end else if (WW'(f_r) + 1'b1 == WW'(frames_r)) begin
          status_nxt = ST_NONE;
          state_nxt  = S_DONE;
        end else begin
          f_nxt     = f_r + 1'b1;
          base_nxt  = step_base;
          state_nxt = S_FRD;
        end
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = status_r;
          out_ff_nxt     = ff_r;
          out_fa_nxt     = fa_r;
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      f_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      f_r         <= f_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r        <= cmd_nxt;
    addr_r       <= addr_nxt;
    len_r        <= len_nxt;
    frames_r     <= frames_nxt;
    limit_r      <= limit_nxt;
    base_r       <= base_nxt;
    last_r       <= last_nxt;
    status_r     <= status_nxt;
    ff_r         <= ff_nxt;
    fa_r         <= fa_nxt;
    out_status_r <= out_status_nxt;
    out_ff_r     <= out_ff_nxt;
    out_fa_r     <= out_fa_nxt;
  end

  assign in_stall          = (state_r != S_IDLE);
  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_found_frame   = out_ff_r;
  assign out_found_address = out_fa_r;

endmodule

// File: hw/rtl/page_frame_occupancy_tracker.sv
// One item at a time, set by the shared divider and the frame table walk; in_stall
// falls as the result is loaded. After reset the frame table is cleared with in_stall
// high; the registers reset to 32 and 1024.
// Top level: APB registers and the sequencer. Depends on pfot_pkg and pfot_ctrl.
`timescale 1ns / 1ps

module page_frame_occupancy_tracker #(
  parameter int unsigned MAX_FRAMES     = 64,
  parameter int unsigned MAX_PAGE_BYTES = 256
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [pfot_pkg::APB_AW-1:0]   paddr,
  input  logic [pfot_pkg::APB_DW-1:0]   pwdata,
  output logic [pfot_pkg::APB_DW-1:0]   prdata,
  output logic                          pready,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [pfot_pkg::CMD_W-1:0]    in_cmd,
  input  logic [pfot_pkg::ADDR_W-1:0]   in_address,
  input  logic [pfot_pkg::LEN_W-1:0]    in_length,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [pfot_pkg::ST_W-1:0]     out_status,
  output logic [pfot_pkg::FF_W-1:0]     out_found_frame,
  output logic [pfot_pkg::ADDR_W-1:0]   out_found_address
);
  import pfot_pkg::*;

  logic [PS_W-1:0] page_size_r;
  logic [MS_W-1:0] memory_size_r;
  logic            wr_en;
  cfg_t            cfg;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      page_size_r   <= PAGE_SIZE_RST;
      memory_size_r <= MEM_SIZE_RST;
    end else if (wr_en) begin
      unique case (paddr[2])
        REG_PAGE_SIZE: page_size_r   <= pwdata[PS_W-1:0];
        REG_MEM_SIZE:  memory_size_r <= pwdata[MS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_PAGE_SIZE: prdata = APB_DW'(page_size_r);
      REG_MEM_SIZE:  prdata = APB_DW'(memory_size_r);
      default:       prdata = '0;
    endcase
  end

  always_comb begin
    if (page_size_r == '0) begin
      cfg.page = PS_W'(1);
    end else if (32'(page_size_r) > MAX_PAGE_BYTES) begin
      cfg.page = PS_W'(MAX_PAGE_BYTES);
    end else begin
      cfg.page = page_size_r;
    end
    cfg.mem = (memory_size_r > MEM_LIMIT) ? MEM_LIMIT : memory_size_r;
  end

  pfot_ctrl #(
    .MAX_FRAMES     (MAX_FRAMES),
    .MAX_PAGE_BYTES (MAX_PAGE_BYTES)
  ) u_ctrl (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg               (cfg),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_cmd            (in_cmd),
    .in_address        (in_address),
    .in_length         (in_length),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_status        (out_status),
    .out_found_frame   (out_found_frame),
    .out_found_address (out_found_address)
  );

endmodule

// File: hw/rtl/pfot_checker.sv
// Port-level checks of the page frame occupancy tracker, bound to the top level.
// Depends on pfot_pkg and page_frame_occupancy_tracker.
`timescale 1ns / 1ps

module pfot_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_stall,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic [pfot_pkg::ST_W-1:0]   out_status,
  input logic [pfot_pkg::FF_W-1:0]   out_found_frame,
  input logic [pfot_pkg::ADDR_W-1:0] out_found_address
);
  import pfot_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second item taken while one is in work");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status <= ST_NONE)
    else $error("undefined status code");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |-> out_found_frame == '0 && out_found_address == '0)
    else $error("error result carries a frame or address");

endmodule

bind page_frame_occupancy_tracker pfot_checker u_pfot_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_valid),
  .in_stall          (in_stall),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_status        (out_status),
  .out_found_frame   (out_found_frame),
  .out_found_address (out_found_address)
);

// File: tb/tb_page_frame_occupancy_tracker.sv
// Self-checking testbench for page_frame_occupancy_tracker: drives mark, free, find and
// undefined-command items through random idle and stall gaps and checks every result against
// a frame table kept here. Depends on pfot_pkg and the tracker RTL.
`timescale 1ns / 1ps

module tb_page_frame_occupancy_tracker;
  import pfot_pkg::*;

  localparam logic [CMD_W-1:0] CMD_NOP = 2'd3;
  localparam logic [APB_AW-1:0] ADDR_PAGE_SIZE = {REG_PAGE_SIZE, 2'b00};
  localparam logic [APB_AW-1:0] ADDR_MEM_SIZE  = {REG_MEM_SIZE, 2'b00};
  localparam int unsigned NFRAMES   = 64;
  localparam int unsigned PAGE_MAX  = 256;
  localparam int unsigned MEM_CAP   = 16384;
  localparam int unsigned N_PHASES  = 11;
  localparam int unsigned N_RANDOM  = 150;
  localparam int unsigned DRAIN_CYC = 300;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [ADDR_W-1:0] address;
    logic [LEN_W-1:0]  length;
  } frame_cmd_t;

  typedef struct packed {
    logic [ST_W-1:0]   status;
    logic [FF_W-1:0]   found_frame;
    logic [ADDR_W-1:0] found_address;
  } frame_rsp_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [APB_AW-1:0] paddr = '0;
  logic [APB_DW-1:0] pwdata = '0;
  logic [APB_DW-1:0] prdata;
  logic pready;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [CMD_W-1:0] in_cmd = '0;
  logic [ADDR_W-1:0] in_address = '0;
  logic [LEN_W-1:0] in_length = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [ST_W-1:0] out_status;
  logic [FF_W-1:0] out_found_frame;
  logic [ADDR_W-1:0] out_found_address;

  page_frame_occupancy_tracker dut (
    .clk(clk), .rst_n(rst_n),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_stall(in_stall), .in_cmd(in_cmd),
    .in_address(in_address), .in_length(in_length),
    .out_valid(out_valid), .out_stall(out_stall), .out_status(out_status),
    .out_found_frame(out_found_frame), .out_found_address(out_found_address)
  );

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  // frame table and register copies
  logic [PS_W-1:0] page_cfg = PAGE_SIZE_RST;
  logic [MS_W-1:0] mem_cfg  = MEM_SIZE_RST;
  logic            frame_busy [NFRAMES];
  int unsigned     frame_fill [NFRAMES];

  frame_cmd_t pending_cmds [$];
  frame_rsp_t expected_rsp [$];
  frame_cmd_t cur_cmd = '0;
  logic       holding = 1'b0;
  int unsigned in_wait = 0;
  int unsigned out_wait = 0;
  int unsigned in_mode = 0;
  int unsigned out_mode = 0;
  int unsigned fail_count = 0;

  initial begin
    for (int i = 0; i < NFRAMES; i++) begin
      frame_busy[i] = 1'b0;
      frame_fill[i] = 0;
    end
  end

  function automatic void page_geometry(output int unsigned p, output int unsigned frames);
    int unsigned m;
    p = page_cfg;
    if (p == 0) p = 1;
    if (p > PAGE_MAX) p = PAGE_MAX;
    m = mem_cfg;
    if (m > MEM_CAP) m = MEM_CAP;
    frames = m / p;
    if (frames > NFRAMES) frames = NFRAMES;
  endfunction

  function automatic frame_rsp_t apply_frame_cmd(frame_cmd_t c);
    int unsigned p, frames, a, n, last_byte, base, lo, hi, top, covered, used, fa;
    frame_rsp_t r;
    r = '0;
    r.status = ST_OK;
    page_geometry(p, frames);
    a = c.address;
    n = c.length;
    case (c.cmd)
      CMD_MARK, CMD_FREE: begin
        if (n == 0) begin
          r.status = ST_ZERO;
        end else if (a + n > frames * p) begin
          r.status = ST_RANGE;
        end else begin
          last_byte = a + n - 1;
          for (int unsigned f = a / p; f <= last_byte / p && f < NFRAMES; f++) begin
            base = f * p;
            lo = (a > base) ? a : base;
            top = base + p - 1;
            hi = (last_byte < top) ? last_byte : top;
            covered = hi - lo + 1;
            used = frame_fill[f];
            if (c.cmd == CMD_MARK) begin
              used += covered;
              if (used > p) used = p;
              frame_busy[f] = 1'b1;
            end else begin
              used = (used > covered) ? used - covered : 0;
              frame_busy[f] = 1'b0;
            end
            frame_fill[f] = used;
          end
        end
      end
      CMD_FIND: begin
        if (n > p) begin
          r.status = ST_LARGE;
        end else begin
          r.status = ST_NONE;
          for (int unsigned f = 0; f < frames; f++) begin
            used = frame_fill[f];
            if (used > p) used = p;
            if (!frame_busy[f] && p - used >= n) begin
              fa = f * p + used;
              r.status = ST_OK;
              r.found_frame = FF_W'(f);
              r.found_address = ADDR_W'(fa);
              break;
            end
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic frame_cmd_t random_frame_cmd();
    int unsigned p, frames, total, pick, maxl, f;
    frame_cmd_t c;
    page_geometry(p, frames);
    total = frames * p;
    pick = $urandom_range(0, 99);
    c.cmd = CMD_NOP;
    c.address = ADDR_W'($urandom_range(0, 16383));
    c.length = LEN_W'($urandom_range(0, 16384));
    if (total == 0 || pick >= 97) begin
      c.cmd = CMD_W'($urandom_range(0, 3));
    end else if (pick < 70) begin
      c.cmd = (pick < 40) ? CMD_MARK : CMD_FREE;
      if ($urandom_range(0, 3) == 0) begin
        f = $urandom_range(0, frames - 1);
        c.address = ADDR_W'(f * p);
        c.length = LEN_W'(p);
      end else begin
        c.address = ADDR_W'($urandom_range(0, total - 1));
        maxl = total - c.address;
        if (maxl > 3 * p) maxl = 3 * p;
        c.length = LEN_W'($urandom_range(1, maxl));
      end
    end else if (pick < 90) begin
      c.cmd = CMD_FIND;
      c.length = ($urandom_range(0, 3) == 0) ? LEN_W'($urandom_range(0, p))
                                             : LEN_W'($urandom_range(0, p / 4));
    end else if (pick < 93) begin
      c.cmd = ($urandom_range(0, 1) == 0) ? CMD_MARK : CMD_FREE;
      c.length = '0;
    end else if (pick < 95) begin
      c.cmd = CMD_FIND;
      c.length = LEN_W'($urandom_range(p + 1, 16384));
    end else begin
      c.cmd = ($urandom_range(0, 1) == 0) ? CMD_MARK : CMD_FREE;
      c.length = LEN_W'($urandom_range(1, 16384));
    end
    return c;
  endfunction

  function automatic int unsigned draw_wait(int unsigned mode);
    case (mode)
      0: return 0;
      1: return $urandom_range(0, 15);
      default: return ($urandom_range(0, 7) == 0) ? $urandom_range(0, 15) : 0;
    endcase
  endfunction

  // input driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      holding = 1'b0;
      in_wait = 0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_rsp.push_back(apply_frame_cmd(cur_cmd));
        holding = 1'b0;
        if ($urandom_range(0, 31) == 0) in_mode = $urandom_range(0, 2);
        in_wait = draw_wait(in_mode);
      end
      if (!holding) begin
        if (in_wait > 0) begin
          in_wait--;
        end else if (pending_cmds.size() != 0) begin
          cur_cmd = pending_cmds.pop_front();
          holding = 1'b1;
        end
      end
      in_valid <= holding;
      in_cmd <= cur_cmd.cmd;
      in_address <= cur_cmd.address;
      in_length <= cur_cmd.length;
    end
  end

  // result monitor
  always @(posedge clk) begin
    frame_rsp_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
      out_wait = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_rsp.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("%0t: result with none expected: status %0d frame %0d address %0d",
                     $realtime, out_status, out_found_frame, out_found_address);
        end else begin
          want = expected_rsp.pop_front();
          if (out_status !== want.status || out_found_frame !== want.found_frame ||
              out_found_address !== want.found_address) begin
            fail_count++;
            if (fail_count <= 10)
              $display("%0t: mismatch: expected status %0d frame %0d address %0d, got %0d %0d %0d",
                       $realtime, want.status, want.found_frame, want.found_address,
                       out_status, out_found_frame, out_found_address);
          end
        end
        if ($urandom_range(0, 31) == 0) out_mode = $urandom_range(0, 2);
        out_wait = draw_wait(out_mode);
      end else if (out_valid && out_wait > 0) begin
        out_wait--;
      end
      out_stall <= (out_wait != 0);
    end
  end

  task automatic cfg_write(input logic [APB_AW-1:0] addr, input logic [APB_DW-1:0] data);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic wait_idle();
    while (pending_cmds.size() != 0 || holding || expected_rsp.size() != 0)
      @(posedge clk);
  endtask

  task automatic queue_cmd(input logic [CMD_W-1:0] cmd, input int unsigned addr,
                           input int unsigned len);
    frame_cmd_t c;
    c.cmd = cmd;
    c.address = ADDR_W'(addr);
    c.length = LEN_W'(len);
    pending_cmds.push_back(c);
  endtask

  initial begin
    int unsigned pg, mem;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // reset geometry: 32 frames of 32 bytes
    queue_cmd(CMD_FIND, 0, 0);
    queue_cmd(CMD_FIND, 0, 32);
    queue_cmd(CMD_FIND, 0, 33);
    queue_cmd(CMD_MARK, 0, 0);
    queue_cmd(CMD_FREE, 5, 0);
    queue_cmd(CMD_MARK, 1000, 25);
    queue_cmd(CMD_MARK, 1000, 24);
    queue_cmd(CMD_MARK, 10, 40);
    queue_cmd(CMD_FIND, 0, 0);
    queue_cmd(CMD_FREE, 10, 5);
    queue_cmd(CMD_FIND, 0, 15);
    queue_cmd(CMD_FIND, 0, 16);
    queue_cmd(CMD_FREE, 0, 100);
    queue_cmd(CMD_MARK, 0, 1024);
    queue_cmd(CMD_FIND, 0, 1);
    queue_cmd(CMD_FIND, 0, 0);
    queue_cmd(CMD_MARK, 0, 64);
    queue_cmd(CMD_NOP, 16383, 16384);
    queue_cmd(CMD_FIND, 16383, 16384);
    queue_cmd(CMD_MARK, 16383, 1);
    queue_cmd(CMD_FREE, 0, 1024);
    queue_cmd(CMD_MARK, 32, 31);
    queue_cmd(CMD_FREE, 32, 1);
    queue_cmd(CMD_FIND, 0, 2);
    queue_cmd(CMD_FIND, 0, 31);

    for (int unsigned ph = 0; ph < N_PHASES; ph++) begin
      if (ph != 0) begin
        case (ph)
          1: begin pg = 256; mem = 16384; end
          2: begin pg = 1;   mem = 64;    end
          3: begin pg = 100; mem = 5000;  end
          4: begin pg = 0;   mem = 5;     end
          5: begin pg = 511; mem = 32767; end
          6: begin pg = 7;   mem = 300;   end
          7: begin pg = 13;  mem = 0;     end
          8: begin pg = 255; mem = 16383; end
          9: begin pg = 64;  mem = 4096;  end
          default: begin pg = 32; mem = 1024; end
        endcase
        wait_idle();
        repeat (2) @(posedge clk);
        cfg_write(ADDR_PAGE_SIZE, APB_DW'(pg));
        page_cfg = PS_W'(pg);
        cfg_write(ADDR_MEM_SIZE, APB_DW'(mem));
        mem_cfg = MS_W'(mem);
        @(posedge clk);
        if (ph == 1) begin
          queue_cmd(CMD_MARK, 0, 16384);
          queue_cmd(CMD_FREE, 16128, 1);
          queue_cmd(CMD_FIND, 0, 0);
          queue_cmd(CMD_FIND, 0, 256);
          queue_cmd(CMD_FREE, 8191, 2);
        end
      end
      for (int unsigned k = 0; k < N_RANDOM; k++)
        pending_cmds.push_back(random_frame_cmd());
    end

    wait_idle();
    repeat (DRAIN_CYC) @(posedge clk);
    if (fail_count == 0 && expected_rsp.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #40_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule
